/* hdl/assert_macros.svh */
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");
`else
`define ASSERT_SAME(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* hdl/twp_pkg.sv */
// Types and constants of the ternary weight packer.
package twp_pkg;

   localparam int WEIGHT_W       = 16;
   localparam int WORD_W         = 32;
   localparam int SCALE_W        = 16;
   localparam int CODES_PER_WORD = 16;
   localparam int SLOT_W         = $clog2(CODES_PER_WORD);
   localparam int QUOT_W         = 16;
   localparam int DCNT_W         = $clog2(QUOT_W);
   localparam int CFG_LEN_W      = 14;
   localparam int CFG_CNT_W      = 16;
   localparam int CSR_IDX_W      = 2;
   localparam int CSR_DATA_W     = 16;

   localparam logic [1:0] CODE_ZERO = 2'b00;
   localparam logic [1:0] CODE_POS  = 2'b01;
   localparam logic [1:0] CODE_NEG  = 2'b10;

   localparam logic KIND_WORD  = 1'b0;
   localparam logic KIND_SCALE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_ROW_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ROW_COUNT  = 2'd1;

   localparam logic [CFG_LEN_W-1:0] ROW_LENGTH_RESET = 14'd16;
   localparam logic [CFG_CNT_W-1:0] ROW_COUNT_RESET  = 16'd1;

   typedef enum logic [1:0] {
      ST_RUN,
      ST_DIV,
      ST_SCALE
   } twp_state_type;

   typedef struct packed {
      logic accept;
      logic div_step;
      logic load_scale;
   } twp_cmd_type;

   typedef struct packed {
      logic out_full;
      logic row_end;
      logic div_last;
   } twp_sts_type;

endpackage

/* hdl/twp_dpath.sv */
// Datapath: config registers, code packing, row sums, scale divider, output register.
`include "assert_macros.svh"

module twp_dpath import twp_pkg::*; #(
   parameter int MAX_ROW_LENGTH = 8192
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_valid,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_data,
   input  logic signed [WEIGHT_W-1:0]  req_weight,
   input  logic                        rsp_stall,
   input  twp_cmd_type                 cmd,
   output twp_sts_type                 sts,
   output logic                        rsp_valid,
   output logic                        rsp_item_kind,
   output logic [WORD_W-1:0]           rsp_packed_word,
   output logic [SCALE_W-1:0]          rsp_row_scale,
   output logic                        rsp_last_of_matrix
);

   localparam int COL_W = $clog2(MAX_ROW_LENGTH + 1);
   localparam int CMP_W = ((COL_W > CFG_LEN_W) ? COL_W : CFG_LEN_W) + 1;
   localparam int SUM_W = WEIGHT_W + COL_W;
   localparam int DVS_W = COL_W + QUOT_W - 1;
   localparam int DIV_W = (SUM_W > DVS_W) ? SUM_W : DVS_W;

   logic [CFG_LEN_W-1:0] row_length_ff;
   logic [CFG_CNT_W-1:0] row_count_ff;

   logic [COL_W-1:0]     col_ff, col_in;
   logic [WORD_W-1:0]    acc_ff, acc_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [COL_W-1:0]     nz_ff, nz_in;
   logic [CFG_CNT_W-1:0] row_ff, row_in;

   logic [DIV_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     dvs_ff;
   logic [QUOT_W-1:0]    quo_ff, quo_in;
   logic                 zero_ff;
   logic                 last_ff;
   logic [DCNT_W-1:0]    div_cnt_ff;

   logic                 out_valid_ff;
   logic                 out_kind_ff;
   logic [WORD_W-1:0]    out_word_ff;
   logic [SCALE_W-1:0]   out_scale_ff;
   logic                 out_last_ff;

   logic [CMP_W-1:0]     len_eff;
   logic [CMP_W-1:0]     col_next;
   logic                 row_end;
   logic [SLOT_W-1:0]    slot;
   logic                 word_emit;
   logic                 neg;
   logic [WEIGHT_W:0]    mag;
   logic [1:0]           code;
   logic [CFG_CNT_W:0]   rows_eff;
   logic [CFG_CNT_W:0]   row_plus;
   logic                 last_row;
   logic                 div_ge;

   always_comb begin
      if (row_length_ff == '0) begin
         len_eff = CMP_W'(1);
      end else if (CMP_W'(row_length_ff) > CMP_W'(MAX_ROW_LENGTH)) begin
         len_eff = CMP_W'(MAX_ROW_LENGTH);
      end else begin
         len_eff = CMP_W'(row_length_ff);
      end
      col_next  = CMP_W'(col_ff) + CMP_W'(1);
      row_end   = col_next >= len_eff;
      slot      = col_ff[SLOT_W-1:0];
      word_emit = (slot == SLOT_W'(CODES_PER_WORD - 1)) || row_end;

      neg = req_weight[WEIGHT_W-1];
      mag = neg ? ((WEIGHT_W+1)'(0) - {1'b1, req_weight}) : {1'b0, req_weight};
      if (req_weight == '0) begin
         code = CODE_ZERO;
      end else if (neg) begin
         code = CODE_NEG;
      end else begin
         code = CODE_POS;
      end

      acc_in = acc_ff | (WORD_W'(code) << {slot, 1'b0});
      sum_in = sum_ff + SUM_W'(mag);
      nz_in  = (code != CODE_ZERO) ? nz_ff + COL_W'(1) : nz_ff;
      col_in = col_next[COL_W-1:0];

      rows_eff = (row_count_ff == '0) ? (CFG_CNT_W+1)'(1) : {1'b0, row_count_ff};
      row_plus = {1'b0, row_ff} + (CFG_CNT_W+1)'(1);
      last_row = row_plus >= rows_eff;
      row_in   = last_row ? '0 : row_plus[CFG_CNT_W-1:0];

      div_ge = rem_ff >= dvs_ff;
      rem_in = div_ge ? rem_ff - dvs_ff : rem_ff;
      quo_in = {quo_ff[QUOT_W-2:0], div_ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff <= ROW_LENGTH_RESET;
         row_count_ff  <= ROW_COUNT_RESET;
         col_ff        <= '0;
         acc_ff        <= '0;
         sum_ff        <= '0;
         nz_ff         <= '0;
         row_ff        <= '0;
         div_cnt_ff    <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               REG_ROW_LENGTH: begin
                  row_length_ff <= csr_data[CFG_LEN_W-1:0];
               end
               REG_ROW_COUNT: begin
                  row_count_ff <= csr_data[CFG_CNT_W-1:0];
               end
               default: begin
               end
            endcase
         end
         if (cmd.accept) begin
            if (row_end) begin
               col_ff <= '0;
               acc_ff <= '0;
               sum_ff <= '0;
               nz_ff  <= '0;
               row_ff <= row_in;
            end else begin
               col_ff <= col_in;
               acc_ff <= word_emit ? '0 : acc_in;
               sum_ff <= sum_in;
               nz_ff  <= nz_in;
            end
         end
         if (cmd.accept && row_end) begin
            div_cnt_ff <= '0;
         end else if (cmd.div_step) begin
            div_cnt_ff <= div_cnt_ff + DCNT_W'(1);
         end
         if ((cmd.accept && word_emit) || cmd.load_scale) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && row_end) begin
         rem_ff  <= DIV_W'(sum_in);
         dvs_ff  <= DIV_W'(nz_in) << (QUOT_W - 1);
         zero_ff <= nz_in == '0;
         last_ff <= last_row;
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         dvs_ff <= dvs_ff >> 1;
         quo_ff <= quo_in;
      end
      if (cmd.accept && word_emit) begin
         out_kind_ff  <= KIND_WORD;
         out_word_ff  <= acc_in;
         out_scale_ff <= '0;
         out_last_ff  <= 1'b0;
      end else if (cmd.load_scale) begin
         out_kind_ff  <= KIND_SCALE;
         out_word_ff  <= '0;
         out_scale_ff <= zero_ff ? '0 : quo_ff;
         out_last_ff  <= last_ff;
      end
   end

   assign sts.out_full = out_valid_ff;
   assign sts.row_end  = row_end;
   assign sts.div_last = div_cnt_ff == DCNT_W'(QUOT_W - 1);

   assign rsp_valid          = out_valid_ff;
   assign rsp_item_kind      = out_kind_ff;
   assign rsp_packed_word    = out_word_ff;
   assign rsp_row_scale      = out_scale_ff;
   assign rsp_last_of_matrix = out_last_ff;

   `ASSERT_NEXT(a_scale_shown, clock, reset, cmd.load_scale,
                out_valid_ff && out_kind_ff == KIND_SCALE)
   `ASSERT_NEXT(a_div_restart, clock, reset, cmd.accept && row_end, div_cnt_ff == '0)

endmodule

/* hdl/twp_ctrl.sv */
// Controller: input acceptance, row-end division sequencing, scale emission.
`include "assert_macros.svh"

module twp_ctrl import twp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        rsp_stall,
   input  twp_sts_type sts,
   output logic        req_stall,
   output twp_cmd_type cmd
);

   twp_state_type state_ff, state_in;
   logic          out_blocked;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      out_blocked = sts.out_full && rsp_stall;
      state_in    = state_ff;
      req_stall   = 1'b1;
      cmd         = '0;
      case (state_ff)
         ST_RUN: begin
            req_stall  = out_blocked;
            cmd.accept = req_valid && !out_blocked;
            if (cmd.accept && sts.row_end) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            if (!out_blocked) begin
               cmd.load_scale = 1'b1;
               state_in       = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   `ASSERT_NEXT(a_row_end_divides, clock, reset,
                state_ff == ST_RUN && cmd.accept && sts.row_end, state_ff == ST_DIV)
   `ASSERT_NEXT(a_div_finishes, clock, reset,
                state_ff == ST_DIV && sts.div_last, state_ff == ST_SCALE)
   `ASSERT_NEXT(a_scale_returns, clock, reset, cmd.load_scale, state_ff == ST_RUN)
   `ASSERT_SAME(a_hold_while_busy, clock, reset, state_ff != ST_RUN, req_stall && !cmd.accept)

endmodule

/* hdl/ternary_weight_packer_core.sv */
// Top level of the ternary weight packer.
// Weights enter one per cycle while req_stall is low, in row-major order, and leave as
// 2-bit ternary codes packed sixteen to a 32-bit word, each row closed by a zero-padded
// word and then the row scale (floor of sum |w| over the nonzero count, 0 for an all-zero
// row). Within a row a weight is taken every cycle while the result side keeps up;
// a single output register holds the pending result. At each row end a restoring divider
// produces one quotient bit per cycle, and then the scale is loaded into the output
// register once it is free. Registers: index 0 row_length, index 1 row_count; csr_ready is
// always high and writes belong between matrices or rows while nothing is in flight.
module ternary_weight_packer_core import twp_pkg::*; #(
   parameter int MAX_ROW_LENGTH = 8192
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_data,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [WEIGHT_W-1:0]  req_weight,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_item_kind,
   output logic [WORD_W-1:0]           rsp_packed_word,
   output logic [SCALE_W-1:0]          rsp_row_scale,
   output logic                        rsp_last_of_matrix
);

   twp_cmd_type cmd;
   twp_sts_type sts;

   assign csr_ready = 1'b1;

   twp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   twp_dpath #(
      .MAX_ROW_LENGTH (MAX_ROW_LENGTH)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid && csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_weight         (req_weight),
      .rsp_stall          (rsp_stall),
      .cmd                (cmd),
      .sts                (sts),
      .rsp_valid          (rsp_valid),
      .rsp_item_kind      (rsp_item_kind),
      .rsp_packed_word    (rsp_packed_word),
      .rsp_row_scale      (rsp_row_scale),
      .rsp_last_of_matrix (rsp_last_of_matrix)
   );

endmodule
